// ===== sv/mps_pkg.sv =====
// Shared types and constants of the Metropolis pixel-swap block.
// No dependencies; used by mps_front, mps_back and the top level.
package mps_pkg;

    localparam int CHANNEL_BITS = 4;
    localparam int SIDE_BITS    = CHANNEL_BITS + CHANNEL_BITS / 2;
    localparam int POS_W        = 2 * SIDE_BITS;
    localparam int NPIX         = 1 << POS_W;
    localparam int COLOR_W      = 3 * CHANNEL_BITS;
    localparam int VMAX         = 1 << CHANNEL_BITS;
    localparam int E1MAX        = VMAX * VMAX * 4 * 3;
    localparam int TABLE_DEPTH  = E1MAX * 2 + 10;
    localparam int TIDX_W       = 13;
    localparam int DRAW_W       = 31;
    localparam int ENERGY_W     = 40;
    localparam int DE_W         = 14;
    localparam int SUM_W        = CHANNEL_BITS + 2;
    localparam int NREADS       = 10;
    localparam int CNT_W        = 4;

    localparam int IN_DATA_W    = 152;
    localparam int OUT_DATA_W   = 96;

    typedef enum logic [1:0] {
        OP_SWAP   = 2'd0,
        OP_PIXEL  = 2'd1,
        OP_TABLE  = 2'd2,
        OP_ENERGY = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DRAIN,
        ST_CALC,
        ST_THRESH,
        ST_DECIDE,
        ST_WRITE1,
        ST_WRITE2,
        ST_RESULT
    } t_back_state;

    // One classified command as it waits in the queue
    typedef struct packed {
        t_op                 op;
        logic [POS_W-1:0]    pos1;
        logic [POS_W-1:0]    pos2;
        logic [DRAW_W-1:0]   draw;
        logic [COLOR_W-1:0]  color;
        logic [TIDX_W-1:0]   tidx;
        logic                tidx_ok;
        logic [DRAW_W-1:0]   tval;
        logic [ENERGY_W-1:0] energy;
    } t_cmd;

    function automatic logic [CHANNEL_BITS-1:0] chan(input logic [COLOR_W-1:0] c,
                                                     input int k);
        return c[k*CHANNEL_BITS +: CHANNEL_BITS];
    endfunction

endpackage

// ===== sv/mps_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module mps_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mps_front.sv =====
// Front end: accepts input items, decodes them into commands, two-entry queue.
// Depends on mps_pkg.
module mps_front
    import mps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    output t_cmd                 o_cmd,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       w_cmd;
    logic       w_push;

    // Decode the item into a command
    always_comb begin
        w_cmd.op      = t_op'(s_axis_tuser);
        w_cmd.pos1    = s_axis_tdata[11:0];
        w_cmd.pos2    = s_axis_tdata[23:12];
        w_cmd.draw    = s_axis_tdata[54:24];
        w_cmd.color   = s_axis_tdata[66:55];
        w_cmd.tidx    = s_axis_tdata[79:67];
        w_cmd.tidx_ok = ({1'b0, s_axis_tdata[79:67]} < (TIDX_W+1)'(TABLE_DEPTH));
        w_cmd.tval    = s_axis_tdata[110:80];
        w_cmd.energy  = s_axis_tdata[150:111];
    end

    assign s_axis_tready = (r_count != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_count != 2'd0);
    assign o_cmd         = r_q[r_rptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (w_push && !(i_cmd_pop && o_cmd_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_cmd_pop && o_cmd_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_cmd_pop && o_cmd_valid) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with full count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_cmd_pop) |=> (r_count != 2'd0))
        else $error("push lost");

endmodule

// ===== sv/mps_back.sv =====
// Back end: sequences pixel and threshold memory accesses for each command,
// computes the energy change, decides the swap and holds the result register.
// Depends on mps_pkg and mps_ram.
module mps_back
    import mps_pkg::*;
#(
    parameter int RANDOM_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int DS_W = CHANNEL_BITS + 4;
    localparam int PR_W = DS_W + CHANNEL_BITS + 1;

    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    logic [CNT_W-1:0] r_cnt;
    logic        r_cap_valid;
    logic [CNT_W-1:0] r_cap_idx;
    logic [COLOR_W-1:0] r_c1, r_c2;
    logic [SUM_W-1:0]   r_s1 [3];
    logic [SUM_W-1:0]   r_s2 [3];
    logic        r_adj;
    logic signed [DE_W-1:0] r_de;
    logic        r_th_ok;
    logic        r_acc;
    logic        r_new_best;
    logic [ENERGY_W-1:0] r_energy, r_best;
    logic        r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Memory ports
    logic               pix_we;
    logic [POS_W-1:0]   pix_waddr, pix_raddr;
    logic [COLOR_W-1:0] pix_wdata, pix_rdata;
    logic               tab_we;
    logic [TIDX_W-1:0]  tab_waddr, tab_raddr;
    logic [RANDOM_BITS-1:0] tab_wdata, tab_rdata;

    logic out_load;
    logic signed [DE_W-1:0] w_de;
    logic [POS_W-1:0] w_rd_addr;
    logic [ENERGY_W-1:0] w_sat;
    logic [RANDOM_BITS-1:0] w_draw;

    mps_ram #(.WIDTH(COLOR_W), .DEPTH(NPIX)) u_pix (
        .i_clk  (i_clk),
        .i_we   (pix_we),
        .i_waddr(pix_waddr),
        .i_wdata(pix_wdata),
        .i_raddr(pix_raddr),
        .o_rdata(pix_rdata)
    );

    mps_ram #(.WIDTH(RANDOM_BITS), .DEPTH(TABLE_DEPTH)) u_tab (
        .i_clk  (i_clk),
        .i_we   (tab_we),
        .i_waddr(tab_waddr),
        .i_wdata(tab_wdata),
        .i_raddr(tab_raddr),
        .o_rdata(tab_rdata)
    );

    assign w_draw = RANDOM_BITS'({1'b0, r_cmd.draw});

    // Read address sequence: c2, c1, four neighbors of pos1, four of pos2
    always_comb begin
        logic [POS_W-1:0] a;
        logic [SIDE_BITS-1:0] x;
        logic [POS_W-SIDE_BITS-1:0] y;
        a = (r_cnt == CNT_W'(0) || r_cnt >= CNT_W'(6)) ? r_cmd.pos2 : r_cmd.pos1;
        x = a[SIDE_BITS-1:0];
        y = a[POS_W-1:SIDE_BITS];
        case (r_cnt)
            CNT_W'(0), CNT_W'(1): w_rd_addr = a;
            CNT_W'(2), CNT_W'(6): w_rd_addr = {y, x - SIDE_BITS'(1)};
            CNT_W'(3), CNT_W'(7): w_rd_addr = {y, x + SIDE_BITS'(1)};
            CNT_W'(4), CNT_W'(8): w_rd_addr = a - POS_W'(1 << SIDE_BITS);
            default:              w_rd_addr = a + POS_W'(1 << SIDE_BITS);
        endcase
    end

    // Energy change from the collected sums
    always_comb begin
        logic signed [DS_W-1:0] ds;
        logic signed [CHANNEL_BITS:0] dc;
        logic signed [PR_W-1:0] pr;
        logic signed [DE_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            ds = $signed(DS_W'(r_s1[k])) - $signed(DS_W'(r_s2[k]));
            if (r_adj) begin
                ds = ds - $signed(DS_W'(chan(r_c2, k))) + $signed(DS_W'(chan(r_c1, k)));
            end
            dc = $signed({1'b0, chan(r_c1, k)}) - $signed({1'b0, chan(r_c2, k)});
            pr = ds * dc;
            acc = acc + DE_W'(pr);
        end
        w_de = acc;
    end

    // Saturated running energy after an accepted swap
    always_comb begin
        logic signed [ENERGY_W+1:0] sum;
        sum = $signed({2'b00, r_energy}) + (ENERGY_W+2)'(r_de);
        if (sum < 0) begin
            w_sat = '0;
        end else if (sum[ENERGY_W]) begin
            w_sat = '1;
        end else begin
            w_sat = sum[ENERGY_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.op == OP_SWAP) ? ST_READ : ST_EXEC;
                end
            end
            ST_EXEC:   n_state = ST_RESULT;
            ST_READ:   if (r_cnt == CNT_W'(NREADS - 1)) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_CALC;
            ST_CALC:   n_state = ST_THRESH;
            ST_THRESH: n_state = r_de[DE_W-1] ? ST_WRITE1 : ST_DECIDE;
            ST_DECIDE: begin
                if (w_draw > (r_th_ok ? tab_rdata : '0)) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_WRITE1;
                end
            end
            ST_WRITE1: n_state = ST_WRITE2;
            ST_WRITE2: n_state = ST_RESULT;
            ST_RESULT: if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_cmd_pop = 1'b0;
        pix_we    = 1'b0;
        pix_waddr = r_cmd.pos1;
        pix_wdata = r_cmd.color;
        pix_raddr = w_rd_addr;
        tab_we    = 1'b0;
        tab_waddr = r_cmd.tidx;
        tab_wdata = RANDOM_BITS'({1'b0, r_cmd.tval});
        tab_raddr = r_de[TIDX_W-1:0];
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: o_cmd_pop = i_cmd_valid;
            ST_EXEC: begin
                pix_we = (r_cmd.op == OP_PIXEL);
                tab_we = (r_cmd.op == OP_TABLE) && r_cmd.tidx_ok;
            end
            ST_WRITE1: begin
                pix_we    = 1'b1;
                pix_waddr = r_cmd.pos1;
                pix_wdata = r_c2;
            end
            ST_WRITE2: begin
                pix_we    = 1'b1;
                pix_waddr = r_cmd.pos2;
                pix_wdata = r_c1;
            end
            ST_RESULT: out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_energy    <= '0;
            r_best      <= '0;
        end else begin
            r_state     <= n_state;
            r_cap_valid <= (r_state == ST_READ);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_EXEC && r_cmd.op == OP_ENERGY) begin
                r_energy <= r_cmd.energy;
                r_best   <= r_cmd.energy;
            end
            if (r_state == ST_WRITE2) begin
                r_energy <= w_sat;
                if (w_sat < r_best) begin
                    r_best <= w_sat;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd_valid) begin
            r_cmd      <= i_cmd;
            r_cnt      <= '0;
            r_adj      <= 1'b0;
            r_acc      <= 1'b0;
            r_new_best <= 1'b0;
            r_de       <= '0;
            for (int k = 0; k < 3; k++) begin
                r_s1[k] <= '0;
                r_s2[k] <= '0;
            end
        end
        if (r_state == ST_READ) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        r_cap_idx <= r_cnt;
        // Collect read data in the cycle after each address
        if (r_cap_valid) begin
            if (r_cap_idx == CNT_W'(0)) begin
                r_c2 <= pix_rdata;
            end else if (r_cap_idx == CNT_W'(1)) begin
                r_c1 <= pix_rdata;
            end else if (r_cap_idx < CNT_W'(6)) begin
                if (pix_rdata == r_c2) r_adj <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    r_s1[k] <= r_s1[k] + SUM_W'(chan(pix_rdata, k));
                end
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_s2[k] <= r_s2[k] + SUM_W'(chan(pix_rdata, k));
                end
            end
        end
        if (r_state == ST_CALC) begin
            r_de <= w_de;
        end
        if (r_state == ST_THRESH) begin
            r_th_ok <= ({1'b0, r_de} < (DE_W+1)'(TABLE_DEPTH));
        end
        if (r_state == ST_WRITE2) begin
            r_acc      <= 1'b1;
            r_new_best <= (w_sat < r_best);
        end
        if (out_load) begin
            r_out_data <= {r_best, r_new_best, r_energy, r_de, r_acc};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_best <= r_energy)
        else $error("best energy above running energy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_THRESH && r_de[DE_W-1]) |=> (r_state == ST_WRITE1))
        else $error("negative change not accepted");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && m_axis_tdata[55]) |-> m_axis_tdata[0])
        else $error("new best without accepted swap");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_we |-> (r_state == ST_EXEC || r_state == ST_WRITE1 || r_state == ST_WRITE2))
        else $error("pixel write outside write states");

endmodule

// ===== sv/metropolis_pixel_swap.sv =====
// Top level of the Metropolis pixel-swap engine: front queue plus back sequencer.
// Depends on mps_pkg, mps_front, mps_back (and mps_ram through mps_back).
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata 152b, tuser 2b (opcode)
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata 96b
//
// A swap holds the back end for ten pixel reads through the single read port
// of the pixel RAM, the change calculation and one threshold read, and, when
// accepted, two pixel writes; a negative change is accepted without the
// threshold comparison. Pixel, table and energy loads go through the execute state.
// Reset (i_rst_n low, synchronous) clears the queue, sequencer, result valid
// flag and both energies; pixel and table memories are not cleared.
// Input stalls only when the two-entry queue is full; output stalls hold
// the back end in its result state.
module metropolis_pixel_swap
    import mps_pkg::*;
#(
    parameter int RANDOM_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // first_position, second_position, random_draw, pixel_color,
    // table_index, table_value, energy_value, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accepted, energy_change, energy_now, new_best, best_energy
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    mps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .o_cmd        (cmd),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_pop    (cmd_pop)
    );

    mps_back #(.RANDOM_BITS(RANDOM_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_pop    (cmd_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule
